// ----- rtl/core/mfcp_pkg.sv -----
// Shared types and constants for the MIDI file chunk parser.
package mfcp_pkg;

    localparam logic [31:0] FILE_MAGIC  = 32'h4d546864;
    localparam logic [31:0] TRACK_MAGIC = 32'h4d54726b;
    localparam logic [15:0] MAX_FORMAT  = 16'd2;

    localparam logic [1:0] KIND_TRACK   = 2'd0;
    localparam logic [1:0] KIND_SUCCESS = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_FILE_MAGIC  = 3'd1;
    localparam logic [2:0] ERR_MAIN_HEADER = 3'd2;
    localparam logic [2:0] ERR_TRACK_MAGIC = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [15:0] index;
        logic [31:0] offset;
        logic [31:0] size;
        logic [15:0] ppq;
        logic [15:0] total;
    } record_t;

    typedef struct packed {
        logic    two;
        record_t rec1;
        record_t rec0;
    } group_t;

endpackage

// ----- rtl/core/mfcp_front.sv -----
// Byte parser: tracks the chunk structure and forms the records each byte causes.
module mfcp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          byte_value,
    input  logic                end_of_buffer,
    output logic                grp_valid,
    output mfcp_pkg::group_t    grp
);
    import mfcp_pkg::*;

    typedef enum logic [5:0] {
        PH_FILE = 6'b000001,
        PH_MAIN = 6'b000010,
        PH_THDR = 6'b000100,
        PH_DATA = 6'b001000,
        PH_DONE = 6'b010000,
        PH_WAIT = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] word_reg, word_next;
    logic [15:0] expected_reg, expected_next;
    logic [15:0] done_reg, done_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] offset_reg, offset_next;
    logic [15:0] timebase_reg, timebase_next;
    logic [31:0] size_reg, size_next;

    logic        do_finish;
    logic [1:0]  n;
    logic [32:0] sum;
    record_t     rec0, rec1, err_rec, trunc_rec;

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        word_next      = word_reg;
        expected_next  = expected_reg;
        done_next      = done_reg;
        remaining_next = remaining_reg;
        offset_next    = offset_reg;
        timebase_next  = timebase_reg;
        size_next      = size_reg;
        do_finish      = 1'b0;
        n              = 2'd0;
        sum            = 33'd0;
        rec0           = '0;
        rec1           = '0;
        err_rec        = '0;
        err_rec.kind   = KIND_ERROR;
        trunc_rec      = '0;
        trunc_rec.kind = KIND_ERROR;
        trunc_rec.err  = ERR_TRUNCATED;

        if (take)
        begin
            count_next = count_reg + 4'd1;
            unique case (phase_reg)
                PH_FILE:
                begin
                    if (count_reg < 4'd4)
                    begin
                        word_next = {word_reg[23:0], byte_value};
                    end
                    if (count_reg == 4'd7)
                    begin
                        count_next = 4'd0;
                        if (word_next != FILE_MAGIC)
                        begin
                            err_rec.err = ERR_FILE_MAGIC;
                            rec0        = err_rec;
                            n           = 2'd1;
                            phase_next  = PH_WAIT;
                        end
                        else
                        begin
                            phase_next = PH_MAIN;
                            word_next  = 32'd0;
                        end
                    end
                end
                PH_MAIN:
                begin
                    if (count_reg < 4'd2)
                    begin
                        word_next = {16'd0, word_reg[7:0], byte_value};
                    end
                    else if (count_reg < 4'd4)
                    begin
                        expected_next = {expected_reg[7:0], byte_value};
                    end
                    else
                    begin
                        timebase_next = {timebase_reg[7:0], byte_value};
                    end
                    if (count_reg == 4'd5)
                    begin
                        count_next = 4'd0;
                        if (word_next[15:0] > MAX_FORMAT || expected_next == 16'd0 ||
                            timebase_next == 16'd0)
                        begin
                            err_rec.err = ERR_MAIN_HEADER;
                            rec0        = err_rec;
                            n           = 2'd1;
                            phase_next  = PH_WAIT;
                        end
                        else
                        begin
                            phase_next = PH_THDR;
                            word_next  = 32'd0;
                            size_next  = 32'd0;
                        end
                    end
                end
                PH_THDR:
                begin
                    if (count_reg < 4'd4)
                    begin
                        word_next = {word_reg[23:0], byte_value};
                    end
                    else
                    begin
                        size_next = {size_reg[23:0], byte_value};
                    end
                    if (count_reg == 4'd7)
                    begin
                        count_next = 4'd0;
                        if (word_next != TRACK_MAGIC)
                        begin
                            err_rec.err = ERR_TRACK_MAGIC;
                            rec0        = err_rec;
                            n           = 2'd1;
                            phase_next  = PH_WAIT;
                        end
                        else if (size_next == 32'd0)
                        begin
                            do_finish = 1'b1;
                        end
                        else
                        begin
                            remaining_next = size_next;
                            phase_next     = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    count_next     = count_reg;
                    remaining_next = remaining_reg - 32'd1;
                    if (remaining_next == 32'd0)
                    begin
                        do_finish = 1'b1;
                    end
                end
                PH_DONE, PH_WAIT:
                begin
                    count_next = count_reg;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase

            if (do_finish)
            begin
                rec0.kind   = KIND_TRACK;
                rec0.err    = ERR_NONE;
                rec0.index  = done_reg;
                rec0.offset = offset_reg;
                rec0.size   = size_next;
                rec0.ppq    = timebase_reg;
                rec0.total  = expected_reg;
                sum         = {1'b0, offset_reg} + {1'b0, size_next};
                offset_next = sum[32] ? 32'hffffffff : sum[31:0];
                done_next   = done_reg + 16'd1;
                if (done_next == expected_reg)
                begin
                    rec1.kind   = KIND_SUCCESS;
                    rec1.offset = offset_next;
                    rec1.ppq    = timebase_reg;
                    rec1.total  = expected_reg;
                    n           = 2'd2;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    n          = 2'd1;
                    phase_next = PH_THDR;
                    word_next  = 32'd0;
                    size_next  = 32'd0;
                end
            end

            if (end_of_buffer)
            begin
                if (phase_next != PH_DONE && phase_next != PH_WAIT)
                begin
                    if (n == 2'd0)
                    begin
                        rec0 = trunc_rec;
                    end
                    else
                    begin
                        rec1 = trunc_rec;
                    end
                    n = n + 2'd1;
                end
                phase_next     = PH_FILE;
                count_next     = 4'd0;
                word_next      = 32'd0;
                expected_next  = 16'd0;
                done_next      = 16'd0;
                remaining_next = 32'd0;
                offset_next    = 32'd0;
                timebase_next  = 16'd0;
                size_next      = 32'd0;
            end
        end
    end

    assign grp_valid = (n != 2'd0);
    assign grp.two   = (n == 2'd2);
    assign grp.rec0  = rec0;
    assign grp.rec1  = rec1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FILE;
            count_reg     <= 4'd0;
            word_reg      <= 32'd0;
            expected_reg  <= 16'd0;
            done_reg      <= 16'd0;
            remaining_reg <= 32'd0;
            offset_reg    <= 32'd0;
            timebase_reg  <= 16'd0;
            size_reg      <= 32'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            word_reg      <= word_next;
            expected_reg  <= expected_next;
            done_reg      <= done_next;
            remaining_reg <= remaining_next;
            offset_reg    <= offset_next;
            timebase_reg  <= timebase_next;
            size_reg      <= size_next;
        end
    end

endmodule

// ----- rtl/core/mfcp_queue.sv -----
// Short register queue of record groups between the parser and the output side.
module mfcp_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  mfcp_pkg::group_t    wr_data,
    input  logic                rd_en,
    output mfcp_pkg::group_t    rd_data,
    output logic                q_full,
    output logic                q_empty
);
    import mfcp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    group_t          store_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign q_full  = (count_reg == DEPTH_C);
    assign q_empty = (count_reg == '0);
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/mfcp_back.sv -----
// Output side: hands out the records of each queued group one beat at a time.
module mfcp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  mfcp_pkg::group_t    head,
    input  logic                q_empty,
    input  logic                pop,
    output logic                deq,
    output mfcp_pkg::record_t   cur,
    output logic                last
);
    import mfcp_pkg::*;

    logic sel_reg, sel_next;

    assign cur  = sel_reg ? head.rec1 : head.rec0;
    assign last = sel_reg || !head.two;
    assign deq  = pop && !q_empty && last;

    always_comb
    begin
        sel_next = sel_reg;
        if (pop && !q_empty)
        begin
            sel_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

endmodule

// ----- rtl/core/midi_file_chunk_parser.sv -----
// Top level of the MIDI file chunk parser: parser, record queue and output side.
//
//   Channel   Handshake      Beat
//   input     push / full    byte_value, end_of_buffer
//   result    pop / empty    record_kind .. last_of_run
//
// One byte is taken every cycle while the record queue has room; the parser
// updates its state in the cycle the byte is accepted and queues the zero to
// two records that byte causes, which appear on the result ports once they reach the queue head.
// The queue holds DEPTH record groups; full rises only when it is filled.
// Reset puts the parser in the file header phase and empties the queue.
module midi_file_chunk_parser
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_value,
    input  logic        end_of_buffer,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  record_kind,
    output logic [2:0]  error_code,
    output logic [15:0] track_index,
    output logic [31:0] track_offset,
    output logic [31:0] track_size,
    output logic [15:0] pulses_per_quarter,
    output logic [15:0] track_total,
    output logic        last_of_run
);
    import mfcp_pkg::*;

    logic    take;
    logic    grp_valid;
    group_t  grp;
    group_t  head;
    logic    q_full;
    logic    q_empty;
    logic    deq;
    record_t cur;
    logic    last;

    assign take  = push && !q_full;
    assign full  = q_full;
    assign empty = q_empty;

    mfcp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .byte_value    (byte_value),
        .end_of_buffer (end_of_buffer),
        .grp_valid     (grp_valid),
        .grp           (grp)
    );

    mfcp_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (grp_valid),
        .wr_data (grp),
        .rd_en   (deq),
        .rd_data (head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    mfcp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .deq     (deq),
        .cur     (cur),
        .last    (last)
    );

    assign record_kind        = cur.kind;
    assign error_code         = cur.err;
    assign track_index        = cur.index;
    assign track_offset       = cur.offset;
    assign track_size         = cur.size;
    assign pulses_per_quarter = cur.ppq;
    assign track_total        = cur.total;
    assign last_of_run        = last;

endmodule

// ----- dv/mfcp_record_checker.sv -----
// Record checker for the MIDI file chunk parser: predicts each result beat and compares it.
module mfcp_record_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  byte_value,
    input  logic        end_of_buffer,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  record_kind,
    input  logic [2:0]  error_code,
    input  logic [15:0] track_index,
    input  logic [31:0] track_offset,
    input  logic [31:0] track_size,
    input  logic [15:0] pulses_per_quarter,
    input  logic [15:0] track_total,
    input  logic        last_of_run,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mfcp_pkg::*;

    typedef enum logic [2:0] {
        SEEK_FILE,
        READ_MAIN,
        READ_TRACK_HDR,
        COUNT_DATA,
        PARSE_DONE,
        SKIP_TO_END
    } parse_phase_t;

    typedef struct packed {
        record_t rec;
        logic    last;
    } record_beat_t;

    record_beat_t  expected_records[$];

    parse_phase_t  phase;
    logic [3:0]    header_count;
    logic [31:0]   shift_word;
    logic [15:0]   tracks_declared;
    logic [15:0]   tracks_finished;
    logic [31:0]   data_left;
    logic [31:0]   offset_sum;
    logic [15:0]   timebase;
    logic [31:0]   chunk_length;

    function automatic record_t make_record(logic [1:0] kind, logic [2:0] err,
                                            logic [15:0] index, logic [31:0] offset,
                                            logic [31:0] length, logic [15:0] ppq,
                                            logic [15:0] total);
        record_t r;
        r.kind   = kind;
        r.err    = err;
        r.index  = index;
        r.offset = offset;
        r.size   = length;
        r.ppq    = ppq;
        r.total  = total;
        return r;
    endfunction

    function automatic void add_record(record_t r);
        record_beat_t b;
        b.rec  = r;
        b.last = 1'b0;
        expected_records.insert(expected_records.size(), b);
    endfunction

    function automatic void clear_parser();
        phase           = SEEK_FILE;
        header_count    = '0;
        shift_word      = '0;
        tracks_declared = '0;
        tracks_finished = '0;
        data_left       = '0;
        offset_sum      = '0;
        timebase        = '0;
        chunk_length    = '0;
    endfunction

    function automatic void raise_error(logic [2:0] code);
        add_record(make_record(KIND_ERROR, code, '0, '0, '0, '0, '0));
        phase = SKIP_TO_END;
    endfunction

    function automatic void close_track();
        logic [32:0] sum;
        sum = {1'b0, offset_sum} + {1'b0, chunk_length};
        add_record(make_record(KIND_TRACK, ERR_NONE, tracks_finished, offset_sum,
                               chunk_length, timebase, tracks_declared));
        offset_sum      = sum[32] ? 32'hffff_ffff : sum[31:0];
        tracks_finished = tracks_finished + 16'd1;
        if (tracks_finished == tracks_declared)
        begin
            add_record(make_record(KIND_SUCCESS, ERR_NONE, '0, offset_sum, '0,
                                   timebase, tracks_declared));
            phase = PARSE_DONE;
        end
        else
        begin
            phase        = READ_TRACK_HDR;
            shift_word   = '0;
            chunk_length = '0;
        end
    endfunction

    function automatic void predict_byte(logic [7:0] value, logic last);
        int first;
        first = expected_records.size();
        case (phase)
            SEEK_FILE:
            begin
                if (header_count < 4'd4)
                    shift_word = {shift_word[23:0], value};
                header_count = header_count + 4'd1;
                if (header_count >= 4'd8)
                begin
                    header_count = '0;
                    if (shift_word != FILE_MAGIC)
                        raise_error(ERR_FILE_MAGIC);
                    else
                    begin
                        phase      = READ_MAIN;
                        shift_word = '0;
                    end
                end
            end
            READ_MAIN:
            begin
                if (header_count < 4'd2)
                    shift_word = {16'd0, shift_word[7:0], value};
                else if (header_count < 4'd4)
                    tracks_declared = {tracks_declared[7:0], value};
                else
                    timebase = {timebase[7:0], value};
                header_count = header_count + 4'd1;
                if (header_count >= 4'd6)
                begin
                    header_count = '0;
                    if (shift_word > {16'd0, MAX_FORMAT} || tracks_declared == '0 ||
                        timebase == '0)
                        raise_error(ERR_MAIN_HEADER);
                    else
                    begin
                        phase        = READ_TRACK_HDR;
                        shift_word   = '0;
                        chunk_length = '0;
                    end
                end
            end
            READ_TRACK_HDR:
            begin
                if (header_count < 4'd4)
                    shift_word = {shift_word[23:0], value};
                else
                    chunk_length = {chunk_length[23:0], value};
                header_count = header_count + 4'd1;
                if (header_count >= 4'd8)
                begin
                    header_count = '0;
                    if (shift_word != TRACK_MAGIC)
                        raise_error(ERR_TRACK_MAGIC);
                    else if (chunk_length == '0)
                        close_track();
                    else
                    begin
                        data_left = chunk_length;
                        phase     = COUNT_DATA;
                    end
                end
            end
            COUNT_DATA:
            begin
                data_left = data_left - 32'd1;
                if (data_left == '0)
                    close_track();
            end
            default:
            begin
            end
        endcase
        if (last)
        begin
            if (phase != PARSE_DONE && phase != SKIP_TO_END)
                raise_error(ERR_TRUNCATED);
            clear_parser();
        end
        if (expected_records.size() > first)
            expected_records[expected_records.size() - 1].last = 1'b1;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_record();
        record_beat_t e;
        if (expected_records.size() == 0)
        begin
            $error("record_kind: expected no beat, actual 0x%0h", record_kind);
            mismatches++;
            return;
        end
        e = expected_records.pop_front();
        compare_field("record_kind", 32'(e.rec.kind), 32'(record_kind));
        compare_field("error_code", 32'(e.rec.err), 32'(error_code));
        compare_field("track_index", 32'(e.rec.index), 32'(track_index));
        compare_field("track_offset", e.rec.offset, track_offset);
        compare_field("track_size", e.rec.size, track_size);
        compare_field("pulses_per_quarter", 32'(e.rec.ppq), 32'(pulses_per_quarter));
        compare_field("track_total", 32'(e.rec.total), 32'(track_total));
        compare_field("last_of_run", 32'(e.last), 32'(last_of_run));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_records.delete();
        end
        else
        begin
            if (pop && !empty)
                check_record();
            if (push && !full)
                predict_byte(byte_value, end_of_buffer);
        end
        outstanding = expected_records.size();
    end

endmodule

// ----- dv/midi_file_chunk_parser_test.sv -----
// Top of the MIDI file chunk parser testbench: clock, reset, byte and pop stimulus and verdict.
module midi_file_chunk_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mfcp_pkg::*;

    localparam int ITEM_TARGET = 1400;
    localparam int CALM_TAIL   = 250;
    localparam int STALL_LIMIT = 1000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        push          = 1'b0;
    logic [7:0]  byte_value    = 8'd0;
    logic        end_of_buffer = 1'b0;
    logic        pop           = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  record_kind;
    logic [2:0]  error_code;
    logic [15:0] track_index;
    logic [31:0] track_offset;
    logic [31:0] track_size;
    logic [15:0] pulses_per_quarter;
    logic [15:0] track_total;
    logic        last_of_run;
    int          mismatches;
    int          outstanding;

    logic        calm       = 1'b0;
    int          bytes_sent = 0;
    int          idle_count = 0;
    logic [7:0]  file_bytes[$];

    midi_file_chunk_parser dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .byte_value         (byte_value),
        .end_of_buffer      (end_of_buffer),
        .empty              (empty),
        .pop                (pop),
        .record_kind        (record_kind),
        .error_code         (error_code),
        .track_index        (track_index),
        .track_offset       (track_offset),
        .track_size         (track_size),
        .pulses_per_quarter (pulses_per_quarter),
        .track_total        (track_total),
        .last_of_run        (last_of_run)
    );

    mfcp_record_checker record_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .byte_value         (byte_value),
        .end_of_buffer      (end_of_buffer),
        .empty              (empty),
        .pop                (pop),
        .record_kind        (record_kind),
        .error_code         (error_code),
        .track_index        (track_index),
        .track_offset       (track_offset),
        .track_size         (track_size),
        .pulses_per_quarter (pulses_per_quarter),
        .track_total        (track_total),
        .last_of_run        (last_of_run),
        .mismatches         (mismatches),
        .outstanding        (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= STALL_LIMIT)
            begin
                $display("midi_file_chunk_parser verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            pop <= 1'b1;
        end
    end

    function automatic void add_byte(logic [7:0] value);
        file_bytes.insert(file_bytes.size(), value);
    endfunction

    function automatic void append_be(logic [31:0] value, int count);
        for (int k = count - 1; k >= 0; k--)
            add_byte(value[8 * k +: 8]);
    endfunction

    function automatic void build_random_file();
        int unsigned pick;
        int unsigned track_count;
        int unsigned spoiled_track;
        int unsigned cut;
        int unsigned data_count;
        logic [31:0] data_len;
        logic [31:0] flip;
        logic [15:0] format_word;
        logic [15:0] tracks_word;
        logic [15:0] timebase_word;
        file_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 24)) add_byte(8'($urandom()));
            return;
        end
        format_word   = 16'($urandom_range(0, 2));
        track_count   = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8)
                                                     : $urandom_range(1, 4);
        tracks_word   = 16'(track_count);
        timebase_word = 16'($urandom_range(1, 65535));
        if (pick < 16)
        begin
            case ($urandom_range(0, 2))
                0:       format_word = 16'($urandom_range(3, 65535));
                1:       tracks_word = 16'd0;
                default: timebase_word = 16'd0;
            endcase
        end
        flip = 32'd1 << $urandom_range(0, 31);
        append_be((pick >= 16 && pick < 22) ? (FILE_MAGIC ^ flip) : FILE_MAGIC, 4);
        append_be($urandom_range(0, 1) ? 32'd6 : $urandom(), 4);
        append_be(32'(format_word), 2);
        append_be(32'(tracks_word), 2);
        append_be(32'(timebase_word), 2);
        spoiled_track = (pick >= 22 && pick < 30) ? $urandom_range(0, track_count - 1)
                                                  : track_count;
        for (int t = 0; t < track_count; t++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    data_len = 32'd0;
                9:       data_len = 32'($urandom_range(13, 60));
                default: data_len = 32'($urandom_range(1, 12));
            endcase
            if (pick >= 30 && pick < 36 && t == track_count - 1)
                data_len = $urandom();
            data_count = (data_len > 32'd60) ? $urandom_range(0, 5) : int'(data_len);
            append_be((t == spoiled_track) ? (TRACK_MAGIC ^ flip) : TRACK_MAGIC, 4);
            append_be(data_len, 4);
            repeat (data_count) add_byte(8'($urandom()));
        end
        if (pick >= 36 && pick < 50)
        begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom()));
        end
    endfunction

    task automatic send_beat(input logic [7:0] value, input logic last);
        @(negedge clk);
        if (!calm && $urandom_range(0, 11) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        push          <= 1'b1;
        byte_value    <= value;
        end_of_buffer <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_beat(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Smallest good file: one empty track, then a trailing byte on the buffer end.
        file_bytes.delete();
        append_be(FILE_MAGIC, 4);
        append_be(32'd6, 4);
        append_be(32'(MAX_FORMAT), 2);
        append_be(32'd1, 2);
        append_be(32'hffff, 2);
        append_be(TRACK_MAGIC, 4);
        append_be(32'd0, 4);
        add_byte(8'hff);
        send_file();
        file_bytes.delete();
        add_byte(8'h00);
        send_file();
        wait_for_results();

        while (bytes_sent < ITEM_TARGET)
        begin
            build_random_file();
            if (bytes_sent >= ITEM_TARGET - CALM_TAIL)
                calm = 1'b1;
            send_file();
            if ($urandom_range(0, 7) == 0)
                wait_for_results();
        end

        @(negedge clk);
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("midi_file_chunk_parser verification clean");
        else
            $display("midi_file_chunk_parser verification failed");
        $finish;
    end

endmodule
